// ===== rtl/core/pfmbt_pkg.sv =====
package pfmbt_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam logic [63:0] AGE_LIMIT_RESET = 64'd10000000000;
  localparam logic [63:0] STAMP_NONE = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic OP_REPORT    = 1'b0;
  localparam logic OP_AGE_CHECK = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] stream_id;
    logic [31:0] bitrate;
    logic [63:0] now_ns;
  } request_t;

  typedef struct packed {
    logic [31:0] min_bitrate;
    logic        min_changed;
    logic        table_full;
  } result_t;

  typedef struct packed {
    logic [31:0] stream;
    logic [31:0] rate;
    logic [63:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_CHECK,
    ST_SWEEP,
    ST_FIN
  } state_t;

  // age wraps modulo 2^64
  function automatic logic is_stale(logic [63:0] now, logic [63:0] stamp,
                                    logic [63:0] interval);
    logic [63:0] age;
    age = now - stamp;
    return age > interval;
  endfunction

endpackage

// ===== rtl/core/pfmbt_ram.sv =====
module pfmbt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pfmbt_ctrl.sv =====
module pfmbt_ctrl #(
  parameter int ENTRIES = pfmbt_pkg::ENTRIES_DEF,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  pfmbt_pkg::request_t           request,
  input  logic [63:0]                   age_limit,
  output logic                          busy,
  output logic                          done,
  output pfmbt_pkg::result_t            result,
  output logic [IDX_W-1:0]              ram_raddr,
  input  logic [$bits(pfmbt_pkg::entry_t)-1:0] ram_rdata,
  output logic                          ram_we,
  output logic [IDX_W-1:0]              ram_waddr,
  output logic [$bits(pfmbt_pkg::entry_t)-1:0] ram_wdata
);

  pfmbt_pkg::state_t   state, state_next;
  pfmbt_pkg::request_t req;
  pfmbt_pkg::entry_t   rd_entry, wr_entry;

  logic [CNT_W-1:0]   iss;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic [31:0]        hit_rate;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [ENTRIES-1:0] valid;
  logic [31:0]        cur_min;
  logic [63:0]        oldest_stamp;
  logic [31:0]        lowest;
  logic [63:0]        oldest;

  logic        issue;
  logic        last;
  logic        fresh;
  logic        full;
  logic        stale_oldest;
  logic        rd_stale;
  logic        sweep_req;
  logic [31:0] fallback;
  logic [31:0] sweep_min;

  assign rd_entry     = pfmbt_pkg::entry_t'(ram_rdata);
  assign issue        = ((state == pfmbt_pkg::ST_SCAN) || (state == pfmbt_pkg::ST_SWEEP))
                        && (iss < CNT_W'(ENTRIES));
  assign last         = rd_vld && (rd_idx == IDX_W'(ENTRIES - 1));
  assign fresh        = !hit_found || (req.bitrate != hit_rate);
  assign full         = !hit_found && !free_found;
  assign stale_oldest = pfmbt_pkg::is_stale(req.now_ns, oldest_stamp, age_limit);
  assign rd_stale     = pfmbt_pkg::is_stale(req.now_ns, rd_entry.stamp, age_limit);
  assign sweep_req    = (fresh && (req.bitrate > cur_min)) || stale_oldest;
  assign fallback     = (req.operation == pfmbt_pkg::OP_AGE_CHECK) ? 32'd0 : req.bitrate;
  assign sweep_min    = ((lowest == 32'd0) && (fallback != 32'd0)) ? fallback : lowest;

  assign wr_entry.stream = req.stream_id;
  assign wr_entry.rate   = req.bitrate;
  assign wr_entry.stamp  = req.now_ns;

  assign busy      = (state != pfmbt_pkg::ST_IDLE);
  assign ram_raddr = iss[IDX_W-1:0];
  assign ram_wdata = wr_entry;
  assign ram_waddr = hit_found ? hit_idx : free_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfmbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    unique case (state)
      pfmbt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (request.operation == pfmbt_pkg::OP_AGE_CHECK)
                       ? pfmbt_pkg::ST_CHECK : pfmbt_pkg::ST_SCAN;
        end
      end
      pfmbt_pkg::ST_SCAN: begin
        if (last) begin
          state_next = pfmbt_pkg::ST_APPLY;
        end
      end
      pfmbt_pkg::ST_APPLY: begin
        ram_we = !full;
        if (!full && (req.bitrate >= cur_min) && sweep_req) begin
          state_next = pfmbt_pkg::ST_SWEEP;
        end else begin
          state_next = pfmbt_pkg::ST_IDLE;
        end
      end
      pfmbt_pkg::ST_CHECK: begin
        state_next = stale_oldest ? pfmbt_pkg::ST_SWEEP : pfmbt_pkg::ST_IDLE;
      end
      pfmbt_pkg::ST_SWEEP: begin
        if (last) begin
          state_next = pfmbt_pkg::ST_FIN;
        end
      end
      pfmbt_pkg::ST_FIN: begin
        state_next = pfmbt_pkg::ST_IDLE;
      end
      default: begin
        state_next = pfmbt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      cur_min      <= 32'd0;
      oldest_stamp <= 64'd0;
      done         <= 1'b0;
      rd_vld       <= 1'b0;
    end else begin
      rd_vld <= issue;
      rd_idx <= iss[IDX_W-1:0];
      if (issue) begin
        iss <= iss + CNT_W'(1);
      end
      case (state)
        pfmbt_pkg::ST_IDLE: begin
          done <= 1'b0;
          if (start) begin
            req        <= request;
            iss        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
          end
        end
        pfmbt_pkg::ST_SCAN: begin
          done <= 1'b0;
          if (rd_vld) begin
            if (valid[rd_idx] && (rd_entry.stream == req.stream_id) && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= rd_idx;
              hit_rate  <= rd_entry.rate;
            end
            if (!valid[rd_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
          end
        end
        pfmbt_pkg::ST_APPLY: begin
          if (!full && !hit_found) begin
            valid[free_idx] <= 1'b1;
          end
          if (full) begin
            done   <= 1'b1;
            result <= '{min_bitrate: cur_min, min_changed: 1'b0, table_full: 1'b1};
          end else if (req.bitrate < cur_min) begin
            cur_min <= req.bitrate;
            done    <= 1'b1;
            result  <= '{min_bitrate: req.bitrate, min_changed: 1'b1, table_full: 1'b0};
          end else if (sweep_req) begin
            done   <= 1'b0;
            iss    <= '0;
            lowest <= 32'd0;
            oldest <= pfmbt_pkg::STAMP_NONE;
          end else begin
            done   <= 1'b1;
            result <= '{min_bitrate: cur_min, min_changed: 1'b0, table_full: 1'b0};
          end
        end
        pfmbt_pkg::ST_CHECK: begin
          if (stale_oldest) begin
            done   <= 1'b0;
            iss    <= '0;
            lowest <= 32'd0;
            oldest <= pfmbt_pkg::STAMP_NONE;
          end else begin
            done   <= 1'b1;
            result <= '{min_bitrate: cur_min, min_changed: 1'b0, table_full: 1'b0};
          end
        end
        pfmbt_pkg::ST_SWEEP: begin
          done <= 1'b0;
          if (rd_vld && valid[rd_idx]) begin
            if (rd_stale) begin
              valid[rd_idx] <= 1'b0;
            end else begin
              if ((lowest == 32'd0) || (rd_entry.rate < lowest)) begin
                lowest <= rd_entry.rate;
              end
              if (rd_entry.stamp < oldest) begin
                oldest <= rd_entry.stamp;
              end
            end
          end
        end
        pfmbt_pkg::ST_FIN: begin
          cur_min      <= sweep_min;
          oldest_stamp <= oldest;
          done         <= 1'b1;
          result       <= '{min_bitrate: sweep_min, min_changed: (sweep_min != cur_min),
                            table_full: 1'b0};
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_back_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == pfmbt_pkg::ST_IDLE)
    else $error("result issued while still working");

  a_full_all_valid: assert property (@(posedge clk) disable iff (rst)
    done && result.table_full |-> &valid)
    else $error("table full reported with a free entry");

  a_min_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> result.min_bitrate == cur_min)
    else $error("published minimum differs from held minimum");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    done && !$past(rst) |-> result.min_changed == (cur_min != $past(cur_min)))
    else $error("change flag disagrees with minimum history");

  a_no_write_outside_apply: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> $past(state) == pfmbt_pkg::ST_SCAN)
    else $error("table written without a finished scan");
`endif

endmodule

// ===== rtl/core/per_flow_min_bitrate_tracker_unit.sv =====
// Keeps one entry per stream (id, bitrate, stamp) in a single-port-read table RAM and
// publishes the minimum bitrate over entries that are not older than age_limit.
// A request is taken when start is high and busy is low; exactly one result follows,
// shown for one cycle with done, and the receiver cannot stall it. The table is walked
// one entry per cycle through the RAM read port: a report does a lookup, a write-back
// and a sweep if triggered; an age check sweeps if the oldest stamp is stale. done is
// high in the first cycle with busy low. Entry valid bits clear at reset, so no
// clearing pass is needed. age_limit is written with cfg_we and cfg_data; the user must
// do so only while no request is in progress, as the block itself does not enforce it.
module per_flow_min_bitrate_tracker_unit #(
  parameter int ENTRIES = pfmbt_pkg::ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pfmbt_pkg::request_t request,
  output logic                busy,
  output logic                done,
  output pfmbt_pkg::result_t  result,
  input  logic                cfg_we,
  input  logic [63:0]         cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ENT_W = $bits(pfmbt_pkg::entry_t);

  logic [63:0]      age_limit;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_rdata;
  logic [ENT_W-1:0] ram_wdata;
  logic             ram_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= pfmbt_pkg::AGE_LIMIT_RESET;
    end else if (cfg_we) begin
      age_limit <= cfg_data;
    end
  end

  pfmbt_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .request       (request),
    .age_limit     (age_limit),
    .busy          (busy),
    .done          (done),
    .result        (result),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata)
  );

  pfmbt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule
